/* src/isotp_pkg.sv */
// Shared types and codes of the ISO-TP receive reassembly block.
`default_nettype none

package isotp_pkg;

	// Frame types taken from the upper nibble of the protocol control byte.
	localparam logic [3:0] FT_SINGLE = 4'd0;
	localparam logic [3:0] FT_FIRST  = 4'd1;
	localparam logic [3:0] FT_CONSEC = 4'd2;

	localparam logic [3:0] SN_MASK = 4'hf;

	// Result kinds.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_FC    = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_SEQUENCE = 2'd0;
	localparam logic [1:0] ERR_FF_BUSY  = 2'd1;
	localparam logic [1:0] ERR_UNEXP_CF = 2'd2;
	localparam logic [1:0] ERR_LENGTH   = 2'd3;

	// Register indexes on the configuration port.
	localparam logic REG_BLOCK_SIZE = 1'b0;
	localparam logic REG_ST_MIN     = 1'b1;

	localparam int QUEUE_DEPTH_DEF = 2;

	// One unit of work handed from the classifier to the result sequencer.
	typedef struct packed {
		logic              is_err;
		logic [1:0]        err_code;
		logic [7:0][7:0]   bytes;
		logic [2:0]        n_data;
		logic [11:0]       base;
		logic [11:0]       length;
		logic              done;
		logic [28:0]       src;
		logic              fc;
		logic [7:0]        fc_bs;
		logic [7:0]        fc_st;
	} job_t;

endpackage

`default_nettype wire

/* src/isotp_if.sv */
// Valid/ready channel interfaces for received frames and result items.
`default_nettype none

interface isotp_frame_if;
	logic        valid;
	logic        ready;
	logic [28:0] can_id;
	logic        id_type;
	logic [3:0]  dlc;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  byte3;
	logic [7:0]  byte4;
	logic [7:0]  byte5;
	logic [7:0]  byte6;
	logic [7:0]  byte7;

	modport source (
		output valid, can_id, id_type, dlc, byte0, byte1, byte2, byte3,
		       byte4, byte5, byte6, byte7,
		input  ready
	);
	modport sink (
		input  valid, can_id, id_type, dlc, byte0, byte1, byte2, byte3,
		       byte4, byte5, byte6, byte7,
		output ready
	);
endinterface

interface isotp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [11:0] byte_offset;
	logic [11:0] message_length;
	logic        message_done;
	logic [28:0] source_id;
	logic [7:0]  fc_block_size;
	logic [7:0]  fc_st_min;
	logic [1:0]  error_code;
	logic        last;

	modport source (
		output valid, kind, data_byte, byte_offset, message_length, message_done,
		       source_id, fc_block_size, fc_st_min, error_code, last,
		input  ready
	);
	modport sink (
		input  valid, kind, data_byte, byte_offset, message_length, message_done,
		       source_id, fc_block_size, fc_st_min, error_code, last,
		output ready
	);
endinterface

`default_nettype wire

/* src/isotp_front.sv */
// Frame classifier: holds the reception state and turns each frame into a job.
`default_nettype none

module isotp_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	isotp_frame_if.sink        frame,
	input  wire logic [7:0]    bs_limit,
	input  wire logic [7:0]    st_min,
	output isotp_pkg::job_t    push_data,
	output logic               push_valid,
	input  wire logic          push_ready
);

	logic        rx_phase_q;
	logic [28:0] peer_id_q;
	logic [3:0]  expected_sn_q;
	logic [11:0] total_length_q;
	logic [11:0] byte_index_q;
	logic [7:0]  block_count_q;

	logic        rx_phase_d;
	logic [28:0] peer_id_d;
	logic [3:0]  expected_sn_d;
	logic [11:0] total_length_d;
	logic [11:0] byte_index_d;
	logic [7:0]  block_count_d;

	logic [3:0]  dlc_eff;
	logic [3:0]  frame_type;
	logic [3:0]  nib;
	logic [11:0] ff_len;
	logic [11:0] remaining;
	logic [2:0]  n_cf;
	logic        cf_done;
	logic [7:0]  bc_next;
	logic        accept;
	logic        emit;
	isotp_pkg::job_t job;

	assign frame.ready = push_ready;
	assign accept      = frame.valid && push_ready;
	assign push_valid  = frame.valid && emit;
	assign push_data   = job;

	assign dlc_eff    = (frame.dlc > 4'd8) ? 4'd8 : frame.dlc;
	assign frame_type = frame.byte0[7:4];
	assign nib        = frame.byte0[3:0];
	assign ff_len     = {nib, frame.byte1};
	assign remaining  = (total_length_q > byte_index_q) ?
	                    (total_length_q - byte_index_q) : 12'd0;
	assign n_cf       = (remaining < 12'd7) ? remaining[2:0] : 3'd7;
	assign cf_done    = (remaining <= 12'd7);
	assign bc_next    = block_count_q + 8'd1;

	always_comb begin
		job            = '0;
		job.src        = frame.can_id;
		job.bytes      = {8'd0, frame.byte7, frame.byte6, frame.byte5, frame.byte4,
		                  frame.byte3, frame.byte2, frame.byte1};
		emit           = 1'b0;
		rx_phase_d     = rx_phase_q;
		peer_id_d      = peer_id_q;
		expected_sn_d  = expected_sn_q;
		total_length_d = total_length_q;
		byte_index_d   = byte_index_q;
		block_count_d  = block_count_q;

		if (dlc_eff != 4'd0) begin
			priority if (frame_type == isotp_pkg::FT_SINGLE) begin
				emit = 1'b1;
				if (nib == 4'd0 || nib > 4'd7 || ({1'b0, dlc_eff} < ({1'b0, nib} + 5'd1))) begin
					job.is_err   = 1'b1;
					job.err_code = isotp_pkg::ERR_LENGTH;
				end else begin
					job.n_data = nib[2:0];
					job.length = {8'd0, nib};
					job.done   = 1'b1;
				end
			end else if (frame_type == isotp_pkg::FT_FIRST) begin
				emit = 1'b1;
				if (rx_phase_q) begin
					job.is_err   = 1'b1;
					job.err_code = isotp_pkg::ERR_FF_BUSY;
				end else if (ff_len < 12'd8 || dlc_eff < 4'd8) begin
					job.is_err   = 1'b1;
					job.err_code = isotp_pkg::ERR_LENGTH;
				end else begin
					job.bytes      = {8'd0, 8'd0, frame.byte7, frame.byte6, frame.byte5,
					                  frame.byte4, frame.byte3, frame.byte2};
					job.n_data     = 3'd6;
					job.length     = ff_len;
					job.fc         = 1'b1;
					job.fc_bs      = bs_limit;
					job.fc_st      = st_min;
					peer_id_d      = frame.can_id;
					total_length_d = ff_len;
					byte_index_d   = 12'd6;
					block_count_d  = 8'd0;
					expected_sn_d  = 4'd1;
					rx_phase_d     = 1'b1;
				end
			end else if (frame_type == isotp_pkg::FT_CONSEC) begin
				if (!rx_phase_q) begin
					emit         = 1'b1;
					job.is_err   = 1'b1;
					job.err_code = isotp_pkg::ERR_UNEXP_CF;
				end else if (frame.can_id != peer_id_q) begin
					// A frame from another sender is dropped silently.
					emit = 1'b0;
				end else if (nib != expected_sn_q) begin
					emit         = 1'b1;
					job.is_err   = 1'b1;
					job.err_code = isotp_pkg::ERR_SEQUENCE;
					rx_phase_d   = 1'b0;
				end else if (dlc_eff < ({1'b0, n_cf} + 4'd1)) begin
					emit         = 1'b1;
					job.is_err   = 1'b1;
					job.err_code = isotp_pkg::ERR_LENGTH;
					rx_phase_d   = 1'b0;
				end else begin
					job.n_data    = n_cf;
					job.base      = byte_index_q;
					job.length    = total_length_q;
					job.done      = cf_done;
					job.src       = peer_id_q;
					byte_index_d  = byte_index_q + {9'd0, n_cf};
					expected_sn_d = (expected_sn_q + 4'd1) & isotp_pkg::SN_MASK;
					if (cf_done) begin
						rx_phase_d = 1'b0;
					end else if (bs_limit != 8'd0) begin
						block_count_d = bc_next;
						if (bc_next >= bs_limit) begin
							block_count_d = 8'd0;
							job.fc        = 1'b1;
							job.fc_bs     = bs_limit;
							job.fc_st     = st_min;
						end
					end
					emit = (n_cf != 3'd0) || job.fc;
				end
			end else begin
				emit = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase_q     <= 1'b0;
			peer_id_q      <= '0;
			expected_sn_q  <= '0;
			total_length_q <= '0;
			byte_index_q   <= '0;
			block_count_q  <= '0;
		end else if (accept) begin
			rx_phase_q     <= rx_phase_d;
			peer_id_q      <= peer_id_d;
			expected_sn_q  <= expected_sn_d;
			total_length_q <= total_length_d;
			byte_index_q   <= byte_index_d;
			block_count_q  <= block_count_d;
		end
	end

endmodule

`default_nettype wire

/* src/isotp_queue.sv */
// Small job queue between the classifier and the result sequencer.
`default_nettype none

module isotp_queue #(
	parameter int DEPTH = isotp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire isotp_pkg::job_t  push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output isotp_pkg::job_t       pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	isotp_pkg::job_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/isotp_back.sv */
// Result sequencer: expands one job into data, flow control or error items.
`default_nettype none

module isotp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_valid,
	output logic                  job_pop,
	input  wire isotp_pkg::job_t  job,
	isotp_result_if.source        result
);

	logic [2:0] idx_q;
	logic [3:0] last_idx;
	logic       emit_last;
	logic       load;
	logic       is_data;

	assign last_idx  = job.is_err ? 4'd0 :
	                   ({1'b0, job.n_data} + {3'd0, job.fc} - 4'd1);
	assign emit_last = ({1'b0, idx_q} == last_idx);
	assign load      = job_valid && (!result.valid || result.ready);
	assign job_pop   = load && emit_last;
	assign is_data   = (idx_q < job.n_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid          <= 1'b0;
			idx_q                 <= '0;
			result.kind           <= isotp_pkg::KIND_DATA;
			result.data_byte      <= '0;
			result.byte_offset    <= '0;
			result.message_length <= '0;
			result.message_done   <= 1'b0;
			result.source_id      <= '0;
			result.fc_block_size  <= '0;
			result.fc_st_min      <= '0;
			result.error_code     <= isotp_pkg::ERR_SEQUENCE;
			result.last           <= 1'b0;
		end else if (load) begin
			result.valid     <= 1'b1;
			idx_q            <= emit_last ? 3'd0 : idx_q + 3'd1;
			result.last      <= emit_last;
			result.source_id <= job.src;
			priority if (job.is_err) begin
				result.kind           <= isotp_pkg::KIND_ERROR;
				result.data_byte      <= '0;
				result.byte_offset    <= '0;
				result.message_length <= '0;
				result.message_done   <= 1'b0;
				result.fc_block_size  <= '0;
				result.fc_st_min      <= '0;
				result.error_code     <= job.err_code;
			end else if (is_data) begin
				result.kind           <= isotp_pkg::KIND_DATA;
				result.data_byte      <= job.bytes[idx_q];
				result.byte_offset    <= job.base + {9'd0, idx_q};
				result.message_length <= job.length;
				result.message_done   <= job.done && (idx_q == job.n_data - 3'd1);
				result.fc_block_size  <= '0;
				result.fc_st_min      <= '0;
				result.error_code     <= isotp_pkg::ERR_SEQUENCE;
			end else begin
				result.kind           <= isotp_pkg::KIND_FC;
				result.data_byte      <= '0;
				result.byte_offset    <= '0;
				result.message_length <= job.length;
				result.message_done   <= 1'b0;
				result.fc_block_size  <= job.fc_bs;
				result.fc_st_min      <= job.fc_st;
				result.error_code     <= isotp_pkg::ERR_SEQUENCE;
			end
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* src/isotp_receiver_reassembly.sv */
// Top level of the ISO-TP receive reassembly block.
//
// Usage: received classic CAN frames enter on the frame channel, one item
// per frame, valid/ready. Results leave on the result channel, one item per
// delivered data byte, flow control request or error; result.last marks the
// final item caused by a frame. Frames that cause nothing (empty, flow
// control or unknown types, foreign consecutive frames) are taken and dropped.
// Block size and STmin are set over the APB port (0x0 and 0x4), by the user
// only while idle; the block itself does not enforce it. A frame's first
// result passes the job queue and then the output register. The sequencer
// emits one result per cycle while the receiver is ready, 1 to 8 per frame;
// frames are accepted every cycle while the job queue (QUEUE_DEPTH entries)
// has room, so classification runs ahead of a busy or stalled output.
// Reset clears the reception state, the queue, the output register and both
// configuration registers. When the result receiver stalls, the output
// register holds its item, the queue fills, and then frame.ready falls.
`default_nettype none

module isotp_receiver_reassembly #(
	parameter int QUEUE_DEPTH = isotp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	isotp_frame_if.sink      frame,
	isotp_result_if.source   result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [7:0]      bs_limit_q;
	logic [7:0]      st_min_q;
	logic            cfg_write;
	isotp_pkg::job_t push_data;
	logic            push_valid;
	logic            push_ready;
	isotp_pkg::job_t pop_data;
	logic            pop_valid;
	logic            pop_ready;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == isotp_pkg::REG_ST_MIN) ? {24'd0, st_min_q} :
	                   {24'd0, bs_limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_limit_q <= '0;
			st_min_q   <= '0;
		end else if (cfg_write) begin
			unique case (paddr[2])
				isotp_pkg::REG_BLOCK_SIZE: bs_limit_q <= pwdata[7:0];
				isotp_pkg::REG_ST_MIN:     st_min_q   <= pwdata[7:0];
				default:                   bs_limit_q <= bs_limit_q;
			endcase
		end
	end

	isotp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame      (frame),
		.bs_limit   (bs_limit_q),
		.st_min     (st_min_q),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	isotp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	isotp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_pop   (pop_ready),
		.job       (pop_data),
		.result    (result)
	);

endmodule

`default_nettype wire
